/* design/cbad_pkg.sv */
// ----------------------------------------------------------------------------
// cbad_pkg
// Shared types and memory map constants of the console bus address decoder.
// ----------------------------------------------------------------------------
package cbad_pkg;

  localparam int ADDR_W   = 32;
  localparam int PHYS_W   = 29;
  localparam int DATA_W   = 32;
  localparam int OFFSET_W = 21;
  localparam int WAIT_W   = 5;
  localparam int LANE_W   = 5;

  typedef enum logic [3:0] {
    T_NONE     = 4'd0,
    T_RAM      = 4'd1,
    T_SCRATCH  = 4'd2,
    T_BIOS     = 4'd3,
    T_IRQSTAT  = 4'd4,
    T_IRQMASK  = 4'd5,
    T_GPUDATA  = 4'd6,
    T_GPUSTAT  = 4'd7,
    T_MDECDATA = 4'd8,
    T_MDECSTAT = 4'd9,
    T_DMA      = 4'd10,
    T_TIMERS   = 4'd11,
    T_SPU      = 4'd12,
    T_SERIAL   = 4'd13,
    T_CDROM    = 4'd14,
    T_MEMCTRL  = 4'd15
  } target_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2,
    SZ_BAD  = 2'd3
  } size_t;

  localparam logic [PHYS_W-1:0] PHYS_MASK      = 29'h1fffffff;
  localparam logic [PHYS_W-1:0] RAM_END        = 29'h0800000;
  localparam logic [PHYS_W-1:0] EXP1_BASE      = 29'h1f000000;
  localparam logic [PHYS_W-1:0] SCRATCH_BASE   = 29'h1f800000;
  localparam logic [PHYS_W-1:0] SCRATCH_END    = 29'h1f800400;
  localparam logic [PHYS_W-1:0] BIOS_BASE      = 29'h1fc00000;
  localparam logic [PHYS_W-1:0] BIOS_END       = 29'h1fc80000;
  localparam logic [PHYS_W-1:0] IRQSTAT_ADDR   = 29'h1f801070;
  localparam logic [PHYS_W-1:0] IRQMASK_ADDR   = 29'h1f801074;
  localparam logic [PHYS_W-1:0] GPUDATA_ADDR   = 29'h1f801810;
  localparam logic [PHYS_W-1:0] GPUSTAT_ADDR   = 29'h1f801814;
  localparam logic [PHYS_W-1:0] MDECDATA_ADDR  = 29'h1f801820;
  localparam logic [PHYS_W-1:0] MDECSTAT_ADDR  = 29'h1f801824;
  localparam logic [PHYS_W-1:0] MEMCTRL_BASE   = 29'h1f801000;
  localparam logic [PHYS_W-1:0] MEMCTRL_END    = 29'h1f801024;
  localparam logic [PHYS_W-1:0] DMA_BASE       = 29'h1f801080;
  localparam logic [PHYS_W-1:0] DMA_END        = 29'h1f8010f8;
  localparam logic [PHYS_W-1:0] TIMER_BASE     = 29'h1f801100;
  localparam logic [PHYS_W-1:0] TIMER_END      = 29'h1f801130;
  localparam logic [PHYS_W-1:0] SPU_BASE       = 29'h1f801c00;
  localparam logic [PHYS_W-1:0] SPU_WR_END     = 29'h1f801e00;
  localparam logic [PHYS_W-1:0] SPU_RD_END     = 29'h1f801fff;
  localparam logic [PHYS_W-1:0] SERIAL_BASE    = 29'h1f801040;
  localparam logic [PHYS_W-1:0] SERIAL_END     = 29'h1f801050;
  localparam logic [PHYS_W-1:0] CDROM_BASE     = 29'h1f801800;
  localparam logic [PHYS_W-1:0] CDROM_END      = 29'h1f801804;

  localparam logic [WAIT_W-1:0] WAIT_RAM    = 5'd4;
  localparam logic [WAIT_W-1:0] WAIT_TIMERS = 5'd2;
  localparam logic [WAIT_W-1:0] WAIT_SPU    = 5'd18;
  localparam logic [WAIT_W-1:0] WAIT_SERIAL = 5'd3;
  localparam logic [WAIT_W-1:0] WAIT_NONE   = 5'd0;

  localparam logic [DATA_W-1:0] IRQ_MASK = 32'h000007ff;

endpackage

/* design/console_bus_address_decoder.sv */
// ----------------------------------------------------------------------------
// console_bus_address_decoder
// Decodes one bus access into target device, local offset, write data, irq
// acknowledge flag, read wait count and byte lane shift. start is taken in
// every cycle (busy is always low); the decode of a beat passes the input
// register and then the result register around a single pass of compare
// logic, and is shown for one cycle on the result ports, marked by done.
// The receiver cannot stall, so every beat yields exactly one result.
// ----------------------------------------------------------------------------
module console_bus_address_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind,
  input  logic [1:0]                      access_size,
  input  logic [cbad_pkg::ADDR_W-1:0]     virtual_address,
  input  logic [cbad_pkg::DATA_W-1:0]     write_value,
  output logic                            done,
  output logic [3:0]                      target,
  output logic [cbad_pkg::OFFSET_W-1:0]   local_offset,
  output logic [cbad_pkg::DATA_W-1:0]     write_data,
  output logic                            acknowledge_and,
  output logic [cbad_pkg::WAIT_W-1:0]     read_wait,
  output logic [cbad_pkg::LANE_W-1:0]     lane_shift
);
  import cbad_pkg::*;

  logic              in_valid;
  logic              in_kind;
  size_t             in_size;
  logic [PHYS_W-1:0] in_addr;
  logic [DATA_W-1:0] in_value;

  target_t             tgt_next;
  logic [OFFSET_W-1:0] off_next;
  logic [DATA_W-1:0]   data_next;
  logic                ack_next;
  logic [WAIT_W-1:0]   wait_next;
  logic [LANE_W-1:0]   lane_next;

  function automatic logic in_win(input logic [PHYS_W-1:0] a,
                                  input logic [PHYS_W-1:0] lo,
                                  input logic [PHYS_W-1:0] hi);
    return (a >= lo) && (a < hi);
  endfunction

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    if (start) begin
      in_kind  <= kind;
      in_size  <= size_t'(access_size);
      in_addr  <= virtual_address[PHYS_W-1:0] & PHYS_MASK;
      in_value <= write_value;
    end
  end

  always_comb begin
    logic [LANE_W-1:0] lane_dma;
    lane_dma  = {in_addr[1:0], 3'b000};
    tgt_next  = T_NONE;
    off_next  = '0;
    data_next = in_value;
    ack_next  = 1'b0;
    lane_next = '0;

    if (in_size == SZ_BAD) begin
      tgt_next = T_NONE;
    end else if (in_addr < RAM_END) begin
      tgt_next = T_RAM;
      off_next = in_addr[20:0];
    end else if (in_win(in_addr, EXP1_BASE, SCRATCH_BASE)) begin
      tgt_next = T_NONE;
    end else if (in_win(in_addr, SCRATCH_BASE, SCRATCH_END)) begin
      tgt_next = T_SCRATCH;
      off_next = OFFSET_W'(in_addr[9:0]);
    end else if (in_win(in_addr, BIOS_BASE, BIOS_END)) begin
      tgt_next = T_BIOS;
      off_next = OFFSET_W'(in_addr[18:0]);
    end else if (in_size != SZ_BYTE && in_addr == IRQSTAT_ADDR) begin
      tgt_next  = T_IRQSTAT;
      data_next = in_value & IRQ_MASK;
      ack_next  = in_kind;
    end else if (in_size != SZ_BYTE && in_addr == IRQMASK_ADDR) begin
      tgt_next  = T_IRQMASK;
      data_next = in_value & IRQ_MASK;
    end else if (in_size == SZ_WORD) begin
      if (in_addr == GPUDATA_ADDR) begin
        tgt_next = T_GPUDATA;
      end else if (in_addr == GPUSTAT_ADDR) begin
        tgt_next = T_GPUSTAT;
      end else if (in_addr == MDECDATA_ADDR) begin
        tgt_next = T_MDECDATA;
      end else if (in_addr == MDECSTAT_ADDR) begin
        tgt_next = T_MDECSTAT;
      end else if (in_kind && in_win(in_addr, MEMCTRL_BASE, MEMCTRL_END)) begin
        tgt_next = T_MEMCTRL;
        off_next = OFFSET_W'(in_addr[5:0]);
      end else if (in_win(in_addr, DMA_BASE, DMA_END)) begin
        tgt_next = T_DMA;
        off_next = OFFSET_W'(in_addr[6:0]);
      end else if (in_win(in_addr, TIMER_BASE, TIMER_END)) begin
        tgt_next = T_TIMERS;
        off_next = OFFSET_W'(in_addr[5:0]);
      end else if (in_kind && in_win(in_addr, SPU_BASE, SPU_WR_END)) begin
        tgt_next = T_SPU;
        off_next = OFFSET_W'(in_addr[9:0]);
      end
    end else if (in_size == SZ_HALF) begin
      if (in_win(in_addr, TIMER_BASE, TIMER_END)) begin
        tgt_next = T_TIMERS;
        off_next = OFFSET_W'(in_addr[5:0]);
      end else if (in_win(in_addr, SPU_BASE, in_kind ? SPU_WR_END : SPU_RD_END)) begin
        tgt_next = T_SPU;
        off_next = OFFSET_W'(in_addr[9:0]);
      end else if (in_win(in_addr, SERIAL_BASE, SERIAL_END)) begin
        tgt_next = T_SERIAL;
        off_next = OFFSET_W'(in_addr[4:0]);
      end
    end else begin
      if (in_win(in_addr, DMA_BASE, DMA_END)) begin
        tgt_next  = T_DMA;
        off_next  = OFFSET_W'(in_addr[6:0]);
        lane_next = lane_dma;
        data_next = {24'h000000, in_value[7:0]} << lane_dma;
      end else if (in_win(in_addr, CDROM_BASE, CDROM_END)) begin
        tgt_next = T_CDROM;
        off_next = OFFSET_W'(in_addr[1:0]);
      end else if (in_win(in_addr, SERIAL_BASE, SERIAL_END)) begin
        tgt_next = T_SERIAL;
        off_next = OFFSET_W'(in_addr[4:0]);
      end
    end

    if (tgt_next == T_NONE) begin
      off_next  = '0;
      data_next = '0;
      ack_next  = 1'b0;
      lane_next = '0;
    end
    if (!in_kind) begin
      data_next = '0;
      ack_next  = 1'b0;
    end

    if (in_kind) begin
      wait_next = WAIT_NONE;
    end else if (in_addr < RAM_END) begin
      wait_next = WAIT_RAM;
    end else if (in_win(in_addr, TIMER_BASE, TIMER_END)) begin
      wait_next = WAIT_TIMERS;
    end else if (in_win(in_addr, SPU_BASE, SPU_RD_END)) begin
      wait_next = WAIT_SPU;
    end else if (in_win(in_addr, SERIAL_BASE, SERIAL_END)) begin
      wait_next = WAIT_SERIAL;
    end else begin
      wait_next = WAIT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    if (in_valid) begin
      target          <= tgt_next;
      local_offset    <= off_next;
      write_data      <= data_next;
      acknowledge_and <= ack_next;
      read_wait       <= wait_next;
      lane_shift      <= lane_next;
    end
  end

endmodule
